// ----- hdl/amf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_pkg: shared types and tables of the ASCII to Morse symbol encoder
// Beat structs of both channels, the work descriptor handed from the front
// to the back end, symbol codes and the decoded letter table.
// ----------------------------------------------------------------------------
package amf_pkg;

    // Default saturation limit of the pending blank counter.
    localparam int MAX_PENDING_BLANKS_DEF = 255;

    // Depth of the descriptor queue between front and back end.
    localparam int QUEUE_DEPTH = 4;

    // Output symbol codes.
    typedef enum logic [1:0] {
        SYM_DOT     = 2'd0,
        SYM_DASH    = 2'd1,
        SYM_SPACE   = 2'd2,
        SYM_NEWLINE = 2'd3
    } symbol_t;

    // ASCII values the front end looks for.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_write;
    } char_beat_t;

    // One output beat.
    typedef struct packed {
        symbol_t    symbol;
        logic [8:0] repeat_count;
        logic       last_of_run;
    } sym_beat_t;

    // Everything one input beat asks the back end to emit, in order:
    // an optional space run, up to four elements, an optional newline.
    typedef struct packed {
        logic       space_en;
        logic [8:0] space_cnt;
        logic [2:0] elem_cnt;
        logic [3:0] elem_dash;   // bit 0 is the first element, 1 means dash
        logic       nl_en;
    } job_t;

    // Letter table, index 0 is 'a'. Each entry is {length, dash mask}.
    // It is the decoded form of the bit-timed code ROM (0xB800 for 'a',
    // 0xEA80 for 'b', ... 0xBBB8 for 'j', ... 0xEEA0 for 'z').
    localparam logic [6:0] LETTER_TAB [32] = '{
        {3'd2, 4'b0010}, {3'd4, 4'b0001}, {3'd4, 4'b0101}, {3'd3, 4'b0001},
        {3'd1, 4'b0000}, {3'd4, 4'b0100}, {3'd3, 4'b0011}, {3'd4, 4'b0000},
        {3'd2, 4'b0000}, {3'd4, 4'b1110}, {3'd3, 4'b0101}, {3'd4, 4'b0010},
        {3'd2, 4'b0011}, {3'd2, 4'b0001}, {3'd3, 4'b0111}, {3'd4, 4'b0110},
        {3'd4, 4'b1011}, {3'd3, 4'b0010}, {3'd3, 4'b0000}, {3'd1, 4'b0001},
        {3'd3, 4'b0100}, {3'd4, 4'b1000}, {3'd3, 4'b0110}, {3'd4, 4'b1001},
        {3'd4, 4'b1101}, {3'd4, 4'b0011}, 7'd0,            7'd0,
        7'd0,            7'd0,            7'd0,            7'd0
    };

endpackage

// ----- hdl/amf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_front: character classifier
// Takes one character beat per cycle while the queue has room, tracks the
// write's whitespace state and pushes a work descriptor when output is due.
// ----------------------------------------------------------------------------
module amf_front
    import amf_pkg::*;
#(
    parameter int MAX_PENDING_BLANKS = MAX_PENDING_BLANKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_beat_t char_beat,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    localparam logic [7:0] BLANK_LIMIT = 8'(MAX_PENDING_BLANKS);

    logic       seen_text_reg, seen_text_next;
    logic       gap_reg, gap_next;
    logic [7:0] blanks_reg, blanks_next;

    logic       accept;
    logic       is_ws;
    logic       alpha_hit;
    logic [7:0] lower;
    logic [7:0] letter_off;
    logic [6:0] letter_ent;
    logic [8:0] run;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;

    // Character classification.
    assign is_ws = (char_beat.char_code == CH_SPACE) || (char_beat.char_code == CH_TAB)
                || (char_beat.char_code == CH_CR)    || (char_beat.char_code == CH_LF);
    assign lower      = char_beat.char_code | CASE_BIT;
    assign alpha_hit  = (lower >= CH_LOW_A) && (lower <= CH_LOW_Z);
    assign letter_off = lower - CH_LOW_A;
    assign letter_ent = LETTER_TAB[letter_off[4:0]];
    assign run        = 9'(gap_reg) + {blanks_reg, 1'b0};

    // State update and descriptor build.
    always_comb
    begin
        seen_text_next = seen_text_reg;
        gap_next       = gap_reg;
        blanks_next    = blanks_reg;
        push_job       = '0;
        push           = 1'b0;
        if (accept)
        begin
            if (is_ws)
            begin
                if (seen_text_reg && (char_beat.char_code == CH_SPACE)
                    && (blanks_reg < BLANK_LIMIT))
                begin
                    blanks_next = blanks_reg + 8'd1;
                end
            end
            else
            begin
                push_job.space_en  = seen_text_reg && (run != 9'd0);
                push_job.space_cnt = run;
                gap_next       = alpha_hit;
                blanks_next    = 8'd0;
                seen_text_next = 1'b1;
                if (alpha_hit)
                begin
                    push_job.elem_cnt  = letter_ent[6:4];
                    push_job.elem_dash = letter_ent[3:0];
                end
            end
            if (char_beat.end_of_write)
            begin
                push_job.nl_en = seen_text_next;
                seen_text_next = 1'b0;
                gap_next       = 1'b0;
                blanks_next    = 8'd0;
            end
            push = push_job.space_en || (push_job.elem_cnt != 3'd0) || push_job.nl_en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_text_reg <= 1'b0;
            gap_reg       <= 1'b0;
            blanks_reg    <= 8'd0;
        end
        else
        begin
            seen_text_reg <= seen_text_next;
            gap_reg       <= gap_next;
            blanks_reg    <= blanks_next;
        end
    end

endmodule

// ----- hdl/amf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_queue: descriptor queue
// Small first-in first-out buffer of work descriptors between the front and
// the back end.
// ----------------------------------------------------------------------------
module amf_queue
    import amf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == CNT_W'(0));
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hdl/amf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_back: symbol emitter
// Walks through one work descriptor at a time and emits one symbol beat per
// cycle, while the receiver does not stall, into a registered output stage.
// ----------------------------------------------------------------------------
module amf_back
    import amf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      head,
    input  logic      q_empty,
    output logic      pop,
    output logic      sym_valid,
    input  logic      sym_ready,
    output sym_beat_t sym_beat
);

    logic      active_reg, active_next;
    job_t      job_reg, job_next;
    logic      valid_reg, valid_next;
    sym_beat_t beat_reg, beat_next;

    job_t      work;
    job_t      rem;
    logic      have;
    logic      load;
    logic      rem_empty;

    assign sym_valid = valid_reg;
    assign sym_beat  = beat_reg;

    // Work from the partly emitted descriptor, or straight from the queue head.
    assign work = active_reg ? job_reg : head;
    assign have = active_reg || !q_empty;
    assign load = have && (!valid_reg || sym_ready);
    assign pop  = load && !active_reg;

    // Pick the next symbol in order: space run, elements, newline.
    always_comb
    begin
        rem                    = work;
        beat_next              = beat_reg;
        beat_next.repeat_count = 9'd1;
        if (work.space_en)
        begin
            beat_next.symbol       = SYM_SPACE;
            beat_next.repeat_count = work.space_cnt;
            rem.space_en           = 1'b0;
        end
        else if (work.elem_cnt != 3'd0)
        begin
            beat_next.symbol = work.elem_dash[0] ? SYM_DASH : SYM_DOT;
            rem.elem_dash    = work.elem_dash >> 1;
            rem.elem_cnt     = work.elem_cnt - 3'd1;
        end
        else
        begin
            beat_next.symbol = SYM_NEWLINE;
            rem.nl_en        = 1'b0;
        end
        rem_empty             = !rem.space_en && (rem.elem_cnt == 3'd0) && !rem.nl_en;
        beat_next.last_of_run = rem_empty;
    end

    // Control of the emitter and output stage.
    always_comb
    begin
        active_next = active_reg;
        valid_next  = valid_reg;
        job_next    = job_reg;
        if (sym_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next  = 1'b1;
            job_next    = rem;
            active_next = !rem_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ----- hdl/ascii_to_morse_symbols.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_to_morse_symbols: ASCII text to Morse symbol encoder
// Turns the bytes of a text write into dot, dash, space-run and newline
// symbols, stripping leading and trailing whitespace.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel takes one ASCII byte per beat with end_of_write set on
//   the last byte of a write. The sym channel returns symbol beats; a space
//   beat carries its run length in repeat_count, and last_of_run marks the
//   final beat caused by one input byte. Bytes that cause nothing (whitespace
//   not ending a write, non-letters with no space run pending) give no output beat.
//   Path: when a byte's beat is taken, the classifier writes its descriptor
//   into the queue; the emitter then loads the first symbol of the byte into
//   the output register.
//   Throughput: one symbol per cycle while the receiver is ready; a byte gives
//   one to six symbols, and a letter with four elements and a space run before
//   it gives five. The front end takes a byte every cycle while the four-entry
//   descriptor queue has room, so bytes that cause nothing pass at full rate.
//   Reset clears the whitespace state, the queue and the output stage.
//   When the receiver stalls, the output beat holds, the emitter stops, the
//   queue fills and char_ready then drops until room frees up.
// ----------------------------------------------------------------------------
module ascii_to_morse_symbols
    import amf_pkg::*;
#(
    parameter int MAX_PENDING_BLANKS = MAX_PENDING_BLANKS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  char_beat_t char_beat,
    output logic       sym_valid,
    input  logic       sym_ready,
    output sym_beat_t  sym_beat
);

    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic q_empty;
    logic q_full;

    amf_front #(
        .MAX_PENDING_BLANKS(MAX_PENDING_BLANKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_beat (char_beat),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    amf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    amf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .sym_valid(sym_valid),
        .sym_ready(sym_ready),
        .sym_beat (sym_beat)
    );

endmodule
